### rtl/tiled_alpha_blend_core_defines.svh
// Assertion macros shared by the tiled alpha blend RTL.
`ifndef TILED_ALPHA_BLEND_CORE_DEFINES_SVH
`define TILED_ALPHA_BLEND_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TAB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TAB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tab_pkg.sv
// Shared types, constants and the per-channel blend function.
`default_nettype none

package tab_pkg;

   // Store and raster limits
   localparam int TILE_PIXELS_MAX = 4096;
   localparam int TILE_ADDR_W     = $clog2(TILE_PIXELS_MAX);
   localparam int LOAD_IDX_W      = $clog2(TILE_PIXELS_MAX + 1);
   localparam int LINE_MAX        = 4096;
   localparam int LINE_W          = $clog2(LINE_MAX + 1);
   localparam int COL_W           = $clog2(LINE_MAX);
   localparam int TILE_DIM_MAX    = 64;
   localparam int TILE_DIM_W      = $clog2(TILE_DIM_MAX + 1);
   localparam int TILE_POS_W      = $clog2(TILE_DIM_MAX);

   // Register and payload widths
   localparam int PIXEL_W         = 32;
   localparam int CHAN_W          = 8;
   localparam int CHANNELS        = PIXEL_W / CHAN_W;
   localparam int ALPHA_W         = 9;
   localparam int ALPHA_ONE       = 256;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 13;

   // Reset values of the registers
   localparam logic [LINE_W-1:0]     IMAGE_WIDTH_RST = LINE_W'(640);
   localparam logic [TILE_DIM_W-1:0] TILE_WIDTH_RST  = TILE_DIM_W'(64);
   localparam logic [TILE_DIM_W-1:0] TILE_HEIGHT_RST = TILE_DIM_W'(64);
   localparam logic [ALPHA_W-1:0]    BLEND_ALPHA_RST = ALPHA_W'(51);

   // Queue between front and back
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH = 2'd0,
      CSR_TILE_WIDTH  = 2'd1,
      CSR_TILE_HEIGHT = 2'd2,
      CSR_BLEND_ALPHA = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_BLEND = 1'b1
   } op_type;

   // Clamped raster geometry handed to the front
   typedef struct packed {
      logic [LINE_W-1:0]     image_width;
      logic [TILE_DIM_W-1:0] tile_width;
      logic [TILE_DIM_W-1:0] tile_height;
   } geom_type;

   // One queued blend job
   typedef struct packed {
      logic [PIXEL_W-1:0] tile_pixel;
      logic [PIXEL_W-1:0] back_pixel;
   } blend_item_type;

   // Round-to-nearest Q1.8 mix of one channel
   function automatic logic [CHAN_W-1:0] blend_lane(input logic [CHAN_W-1:0] fg,
                                                    input logic [CHAN_W-1:0] bg,
                                                    input logic [ALPHA_W-1:0] alpha);
      logic [ALPHA_W-1:0]  inv_alpha;
      logic [17:0]         sum;
      logic [9:0]          quot;
      inv_alpha = ALPHA_W'(ALPHA_ONE) - alpha;
      sum  = 18'(fg) * 18'(alpha) + 18'(bg) * 18'(inv_alpha) + 18'd128;
      quot = sum[17:8];
      return (quot > 10'd255) ? {CHAN_W{1'b1}} : quot[CHAN_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/tab_fifo.sv
// Short queue of blend jobs between the front and the back.
`default_nettype none
`include "tiled_alpha_blend_core_defines.svh"

module tab_fifo
   import tab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire blend_item_type         push_item,
   input  wire logic                   pop,
   output      blend_item_type         head_item,
   output      logic [QUEUE_CNT_W-1:0] level
);

   blend_item_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed beats
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign level     = count_ff;

   `TAB_ASSERT_NOW(a_no_overflow, push && !pop, count_ff < QUEUE_CNT_W'(QUEUE_DEPTH), "queue overflow")
   `TAB_ASSERT_NOW(a_no_underflow, pop, count_ff != '0, "queue underflow")

endmodule

`default_nettype wire

### rtl/tab_front.sv
// Front end: accepts beats, keeps the raster counters, loads and reads the tile store.
`default_nettype none
`include "tiled_alpha_blend_core_defines.svh"

module tab_front
   import tab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire geom_type               geom,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_op,
   input  wire logic [PIXEL_W-1:0]     req_pixel,
   input  wire logic                   req_frame_start,
   input  wire logic [QUEUE_CNT_W-1:0] queue_level,
   output      logic                   push,
   output      blend_item_type         push_item
);

   logic [PIXEL_W-1:0]     tile_store [TILE_PIXELS_MAX];

   logic [LOAD_IDX_W-1:0]  load_index_ff, load_index_in;
   logic [COL_W-1:0]       column_count_ff, column_count_in;
   logic [TILE_POS_W-1:0]  tile_column_ff, tile_column_in;
   logic [TILE_POS_W-1:0]  tile_row_ff, tile_row_in;
   logic                   s1_valid_ff;
   logic [PIXEL_W-1:0]     s1_tile_ff;
   logic [PIXEL_W-1:0]     s1_back_ff;

   logic                   accept;
   logic                   is_blend;
   logic                   load_wr;
   logic [LOAD_IDX_W-1:0]  load_base;
   logic [COL_W-1:0]       col_base;
   logic [TILE_POS_W-1:0]  tcol_base, trow_base;
   logic [TILE_POS_W-1:0]  tcol_cur, trow_cur;
   logic [TILE_DIM_W-1:0]  tcol_inc, trow_inc;
   logic [LINE_W-1:0]      col_inc;
   logic [LINE_W-1:0]      row_start;
   logic [LINE_W-1:0]      addr_sum;
   logic [TILE_ADDR_W-1:0] rd_addr;

   // Take a beat while the queue has room for it and the one in flight
   assign req_stall = (QUEUE_CNT_W'(queue_level) + QUEUE_CNT_W'(s1_valid_ff))
                      >= QUEUE_CNT_W'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign is_blend  = (op_type'(req_op) == OP_BLEND);

   // Restart counters on frame start and re-wrap against current limits
   always_comb begin
      load_base = req_frame_start ? '0 : load_index_ff;
      col_base  = req_frame_start ? '0 : column_count_ff;
      tcol_base = req_frame_start ? '0 : tile_column_ff;
      trow_base = req_frame_start ? '0 : tile_row_ff;
      tcol_cur  = (TILE_DIM_W'(tcol_base) >= geom.tile_width)  ? '0 : tcol_base;
      trow_cur  = (TILE_DIM_W'(trow_base) >= geom.tile_height) ? '0 : trow_base;
      row_start = LINE_W'(trow_cur) * LINE_W'(geom.tile_width);
      addr_sum  = row_start + LINE_W'(tcol_cur);
      rd_addr   = addr_sum[TILE_ADDR_W-1:0];
      load_wr   = accept && !is_blend && (load_base < LOAD_IDX_W'(TILE_PIXELS_MAX));
   end

   // Next counter values
   always_comb begin
      load_index_in   = load_index_ff;
      column_count_in = column_count_ff;
      tile_column_in  = tile_column_ff;
      tile_row_in     = tile_row_ff;
      tcol_inc        = TILE_DIM_W'(tcol_cur) + TILE_DIM_W'(1);
      trow_inc        = TILE_DIM_W'(trow_cur) + TILE_DIM_W'(1);
      col_inc         = LINE_W'(col_base) + LINE_W'(1);
      if (accept && !is_blend) begin
         load_index_in = load_wr ? load_base + LOAD_IDX_W'(1) : load_base;
      end else if (accept) begin
         if (col_inc >= geom.image_width) begin
            column_count_in = '0;
            tile_column_in  = '0;
            tile_row_in     = (trow_inc >= geom.tile_height) ? '0 : trow_inc[TILE_POS_W-1:0];
         end else begin
            column_count_in = col_inc[COL_W-1:0];
            tile_column_in  = (tcol_inc >= geom.tile_width) ? '0 : tcol_inc[TILE_POS_W-1:0];
            tile_row_in     = trow_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff   <= '0;
         column_count_ff <= '0;
         tile_column_ff  <= '0;
         tile_row_ff     <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         load_index_ff   <= load_index_in;
         column_count_ff <= column_count_in;
         tile_column_ff  <= tile_column_in;
         tile_row_ff     <= tile_row_in;
         s1_valid_ff     <= accept && is_blend;
      end
   end

   // Write tile pixels, read the tile pixel under each background beat
   always_ff @(posedge clock) begin
      if (load_wr) begin
         tile_store[load_base[TILE_ADDR_W-1:0]] <= req_pixel;
      end
      if (accept && is_blend) begin
         s1_tile_ff <= tile_store[rd_addr];
         s1_back_ff <= req_pixel;
      end
   end

   assign push                 = s1_valid_ff;
   assign push_item.tile_pixel = s1_tile_ff;
   assign push_item.back_pixel = s1_back_ff;

   `TAB_ASSERT_NOW(a_load_index_bound, 1'b1, load_index_ff <= LOAD_IDX_W'(TILE_PIXELS_MAX), "load index past store")
   `TAB_ASSERT_NEXT(a_blend_issues, accept && is_blend, s1_valid_ff, "blend beat not issued")

endmodule

`default_nettype wire

### rtl/tab_back.sv
// Back end: blends queued jobs and holds the result beat in an output register.
`default_nettype none

module tab_back
   import tab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [ALPHA_W-1:0]     alpha,
   input  wire logic [QUEUE_CNT_W-1:0] queue_level,
   input  wire blend_item_type         head_item,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [PIXEL_W-1:0]     rsp_blended_pixel
);

   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic [PIXEL_W-1:0] mixed;
   logic               slot_free;

   // Mix each byte lane on its own
   always_comb begin
      for (int lane = 0; lane < CHANNELS; lane++) begin
         mixed[lane*CHAN_W +: CHAN_W] = blend_lane(head_item.tile_pixel[lane*CHAN_W +: CHAN_W],
                                                   head_item.back_pixel[lane*CHAN_W +: CHAN_W],
                                                   alpha);
      end
   end

   // Pop when the output register is empty or being drained
   assign slot_free    = !out_valid_ff || !rsp_stall;
   assign pop          = slot_free && (queue_level != '0);
   assign out_valid_in = slot_free ? (queue_level != '0) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_pixel_ff <= mixed;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_blended_pixel = out_pixel_ff;

endmodule

`default_nettype wire

### rtl/tiled_alpha_blend_core.sv
// Top level of the tiled alpha blend core: registers, front, queue and back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  req     | in        | req_valid/req_stall  | req_op, req_pixel, req_frame_start
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_blended_pixel
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One beat per clock while req_stall is low; a blend result goes through the store
// read register, the queue and the output register. Loads give no result.
// The rate is set by the single-port tile store, which takes one write or one
// read each cycle. Reset is synchronous and needs no clearing pass; the store
// holds garbage until loaded. A stall on rsp fills the four-entry queue; req_stall
// rises once queued and in-flight jobs reach four; csr writes are always taken.
`default_nettype none

module tiled_alpha_blend_core
   import tab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_op,
   input  wire logic [PIXEL_W-1:0]     req_pixel,
   input  wire logic                   req_frame_start,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [PIXEL_W-1:0]     rsp_blended_pixel,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [LINE_W-1:0]      image_width_ff;
   logic [TILE_DIM_W-1:0]  tile_width_ff;
   logic [TILE_DIM_W-1:0]  tile_height_ff;
   logic [ALPHA_W-1:0]     blend_alpha_ff;

   geom_type               geom;
   logic [ALPHA_W-1:0]     alpha_eff;
   logic [QUEUE_CNT_W-1:0] queue_level;
   logic                   push;
   logic                   pop;
   blend_item_type         push_item;
   blend_item_type         head_item;

   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMAGE_WIDTH_RST;
         tile_width_ff  <= TILE_WIDTH_RST;
         tile_height_ff <= TILE_HEIGHT_RST;
         blend_alpha_ff <= BLEND_ALPHA_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata[LINE_W-1:0];
            CSR_TILE_WIDTH:  tile_width_ff  <= csr_wdata[TILE_DIM_W-1:0];
            CSR_TILE_HEIGHT: tile_height_ff <= csr_wdata[TILE_DIM_W-1:0];
            CSR_BLEND_ALPHA: blend_alpha_ff <= csr_wdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp register values into their working ranges
   always_comb begin
      if (image_width_ff == '0) begin
         geom.image_width = LINE_W'(1);
      end else if (image_width_ff > LINE_W'(LINE_MAX)) begin
         geom.image_width = LINE_W'(LINE_MAX);
      end else begin
         geom.image_width = image_width_ff;
      end
      if (tile_width_ff == '0) begin
         geom.tile_width = TILE_DIM_W'(1);
      end else if (tile_width_ff > TILE_DIM_W'(TILE_DIM_MAX)) begin
         geom.tile_width = TILE_DIM_W'(TILE_DIM_MAX);
      end else begin
         geom.tile_width = tile_width_ff;
      end
      if (tile_height_ff == '0) begin
         geom.tile_height = TILE_DIM_W'(1);
      end else if (tile_height_ff > TILE_DIM_W'(TILE_DIM_MAX)) begin
         geom.tile_height = TILE_DIM_W'(TILE_DIM_MAX);
      end else begin
         geom.tile_height = tile_height_ff;
      end
      alpha_eff = (blend_alpha_ff > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : blend_alpha_ff;
   end

   tab_front u_front (
      .clock           (clock),
      .reset           (reset),
      .geom            (geom),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .queue_level     (queue_level),
      .push            (push),
      .push_item       (push_item)
   );

   tab_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .level     (queue_level)
   );

   tab_back u_back (
      .clock             (clock),
      .reset             (reset),
      .alpha             (alpha_eff),
      .queue_level       (queue_level),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blended_pixel (rsp_blended_pixel)
   );

endmodule

`default_nettype wire
